### rtl/gdu_pkg.sv
`default_nettype none
package gdu_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned NUM_W    = 23;
    localparam int unsigned GAP_W    = 22;
    localparam logic [3:0]  MONTHS   = 4'd12;

    // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT, exact for y < 2^15
    localparam logic [14:0] RECIP_100   = 15'd20972;
    localparam int unsigned RECIP_SHIFT = 21;

    localparam logic [1:0] ORD_EARLIER = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_LATER   = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
    } t_date;

    typedef struct packed {
        t_date       a;
        t_date       b;
        logic [7:0]  q_a;
        logic [7:0]  q_b;
        logic [1:0]  order;
    } t_s1;

    typedef struct packed {
        logic              leap;
        logic [12:0]       c4;
        logic [7:0]        c100;
        logic [5:0]        c400;
    } t_yterm;

    typedef struct packed {
        logic              valid_a;
        logic              valid_b;
        logic [1:0]        order;
        logic              leap_a;
        logic [4:0]        month_days_a;
        logic [4:0]        next_day;
        logic [4:0]        next_month;
        logic [YEAR_W-1:0] next_year;
        logic [YEAR_W-1:0] year_a;
        logic [YEAR_W-1:0] year_b;
        logic [12:0]       off_a;
        logic [12:0]       off_b;
    } t_s2;

    typedef struct packed {
        logic              valid_a;
        logic              valid_b;
        logic [1:0]        order;
        logic              leap_a;
        logic [4:0]        month_days_a;
        logic [4:0]        next_day;
        logic [4:0]        next_month;
        logic [YEAR_W-1:0] next_year;
        logic [NUM_W-1:0]  num_a;
        logic [NUM_W-1:0]  num_b;
    } t_s3;

    typedef struct packed {
        logic              valid_a;
        logic              valid_b;
        logic [1:0]        order;
        logic [GAP_W-1:0]  day_gap;
        logic              leap_a;
        logic [4:0]        month_days_a;
        logic [4:0]        next_day;
        logic [4:0]        next_month;
        logic [YEAR_W-1:0] next_year;
    } t_res;

endpackage
`default_nettype wire

### rtl/gdu_prep.sv
`default_nettype none
module gdu_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire gdu_pkg::t_date i_a,
    input  wire gdu_pkg::t_date i_b,
    output logic               o_valid,
    input  wire logic          i_ready,
    output gdu_pkg::t_s1       o_data
);
    import gdu_pkg::*;

    logic        r_valid;
    t_s1         r_data;
    t_s1         n_data;
    logic [28:0] prod_a;
    logic [28:0] prod_b;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        prod_a = 29'(i_a.year) * 29'(RECIP_100);
        prod_b = 29'(i_b.year) * 29'(RECIP_100);
        n_data.a   = i_a;
        n_data.b   = i_b;
        n_data.q_a = prod_a[RECIP_SHIFT +: 8];
        n_data.q_b = prod_b[RECIP_SHIFT +: 8];
        // year, then month, then day: the packed date compares lexicographically
        if (i_a == i_b) begin
            n_data.order = ORD_EQUAL;
        end else if (i_a > i_b) begin
            n_data.order = ORD_LATER;
        end else begin
            n_data.order = ORD_EARLIER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### rtl/gdu_cal.sv
`default_nettype none
module gdu_cal #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire gdu_pkg::t_s1 i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output gdu_pkg::t_s2     o_data
);
    import gdu_pkg::*;

    localparam logic [31:0] MaxYr = 32'(MAX_YEAR);

    function automatic t_yterm year_terms(logic [YEAR_W-1:0] y, logic [7:0] q);
        logic [YEAR_W-1:0] q100;
        logic [6:0]        r;
        logic              r_nz;
        t_yterm            t;
        q100   = YEAR_W'(q) * YEAR_W'(100);
        r      = 7'(y - q100);
        r_nz   = (r != 7'd0);
        t.leap = ((y[1:0] == 2'd0) && r_nz) || (!r_nz && (q[1:0] == 2'd0));
        t.c4   = 13'((15'(y) + 15'd3) >> 2);
        t.c100 = q + 8'(r_nz);
        t.c400 = 6'(q >> 2) + 6'(r_nz || (q[1:0] != 2'd0));
        return t;
    endfunction

    function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
        logic [4:0] n;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] days_before(logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [12:0] year_offset(t_date d, t_yterm t);
        logic adj;
        adj = (d.month > 4'd2) && t.leap;
        return t.c4 - 13'(t.c100) + 13'(t.c400) + 13'(days_before(d.month))
             + 13'(adj) + 13'(d.day);
    endfunction

    function automatic logic date_ok(t_date d, logic [4:0] mlen);
        return (32'(d.year) <= MaxYr) && (d.month >= 4'd1) && (d.month <= MONTHS)
            && (d.day >= 5'd1) && (d.day <= mlen);
    endfunction

    logic   r_valid;
    t_s2    r_data;
    t_s2    n_data;
    t_yterm ta;
    t_yterm tb;
    logic [4:0] mlen_a;
    logic [4:0] mlen_b;
    logic [4:0] nm;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        ta     = year_terms(i_data.a.year, i_data.q_a);
        tb     = year_terms(i_data.b.year, i_data.q_b);
        mlen_a = month_len(i_data.a.month, ta.leap);
        mlen_b = month_len(i_data.b.month, tb.leap);

        n_data.valid_a      = date_ok(i_data.a, mlen_a);
        n_data.valid_b      = date_ok(i_data.b, mlen_b);
        n_data.order        = i_data.order;
        n_data.leap_a       = ta.leap;
        n_data.month_days_a = mlen_a;
        n_data.year_a       = i_data.a.year;
        n_data.year_b       = i_data.b.year;
        n_data.off_a        = year_offset(i_data.a, ta);
        n_data.off_b        = year_offset(i_data.b, tb);

        // advance the day, else roll to the first of the next month or year
        nm = 5'(i_data.a.month) + 5'd1;
        n_data.next_day   = 5'd1;
        n_data.next_month = nm;
        n_data.next_year  = i_data.a.year;
        if (mlen_a > i_data.a.day) begin
            n_data.next_day   = i_data.a.day + 5'd1;
            n_data.next_month = 5'(i_data.a.month);
        end else if (nm > 5'(MONTHS)) begin
            n_data.next_month = 5'd1;
            n_data.next_year  = i_data.a.year + YEAR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### rtl/gdu_num.sv
`default_nettype none
module gdu_num (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire gdu_pkg::t_s2 i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output gdu_pkg::t_s3     o_data
);
    import gdu_pkg::*;

    logic r_valid;
    t_s3  r_data;
    t_s3  n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.valid_a      = i_data.valid_a;
        n_data.valid_b      = i_data.valid_b;
        n_data.order        = i_data.order;
        n_data.leap_a       = i_data.leap_a;
        n_data.month_days_a = i_data.month_days_a;
        n_data.next_day     = i_data.next_day;
        n_data.next_month   = i_data.next_month;
        n_data.next_year    = i_data.next_year;
        n_data.num_a = NUM_W'(i_data.year_a) * NUM_W'(365) + NUM_W'(i_data.off_a);
        n_data.num_b = NUM_W'(i_data.year_b) * NUM_W'(365) + NUM_W'(i_data.off_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### rtl/gdu_gap.sv
`default_nettype none
module gdu_gap (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire gdu_pkg::t_s3 i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output gdu_pkg::t_res    o_data
);
    import gdu_pkg::*;

    logic             r_valid;
    t_res             r_data;
    t_res             n_data;
    logic [NUM_W-1:0] diff;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        diff = (i_data.num_a >= i_data.num_b) ? i_data.num_a - i_data.num_b
                                              : i_data.num_b - i_data.num_a;
        n_data.valid_a      = i_data.valid_a;
        n_data.valid_b      = i_data.valid_b;
        n_data.order        = i_data.order;
        n_data.leap_a       = i_data.leap_a;
        n_data.month_days_a = i_data.month_days_a;
        n_data.next_day     = i_data.next_day;
        n_data.next_month   = i_data.next_month;
        n_data.next_year    = i_data.next_year;
        if (!(i_data.valid_a && i_data.valid_b)) begin
            n_data.day_gap = '0;
        end else if (diff[NUM_W-1:GAP_W] != '0) begin
            // saturate
            n_data.day_gap = '1;
        end else begin
            n_data.day_gap = diff[GAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### rtl/gregorian_date_unit.sv
`default_nettype none
// channel    dir  bits  word
// s_axis     in   48    two dates A and B
// m_axis     out  56    validity, order, gap and the date after A
//
// Four register stages: reciprocal divide by 100, calendar terms, day
// numbers, gap. A word taken at s_axis passes through each of them in turn
// before m_axis_tvalid rises; one word enters per cycle while nothing stalls.
// Reset clears the stage valid bits only. Each stage takes a word while it is
// empty or its own word moves on, so bubbles fill up during an output stall
// and nothing is lost or repeated.
module gregorian_date_unit #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // day_a[4:0] month_a[8:5] year_a[22:9] day_b[27:23] month_b[31:28] year_b[45:32]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // valid_a[0] valid_b[1] order[3:2] day_gap[25:4] leap_a[26] month_days_a[31:27]
    // next_day[36:32] next_month[41:37] next_year[55:42]
    output logic [55:0]      m_axis_tdata
);
    import gdu_pkg::*;

    t_date date_a;
    t_date date_b;
    t_s1   s1_data;
    t_s2   s2_data;
    t_s3   s3_data;
    t_res  res;
    logic  s1_valid;
    logic  s2_valid;
    logic  s3_valid;
    logic  s2_ready;
    logic  s3_ready;
    logic  s4_ready;

    assign date_a.day   = s_axis_tdata[4:0];
    assign date_a.month = s_axis_tdata[8:5];
    assign date_a.year  = s_axis_tdata[22:9];
    assign date_b.day   = s_axis_tdata[27:23];
    assign date_b.month = s_axis_tdata[31:28];
    assign date_b.year  = s_axis_tdata[45:32];

    gdu_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_a     (date_a),
        .i_b     (date_b),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_data  (s1_data)
    );

    gdu_cal #(
        .MAX_YEAR (MAX_YEAR)
    ) u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s3_ready),
        .o_data  (s2_data)
    );

    gdu_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s4_ready),
        .o_data  (s3_data)
    );

    gdu_gap u_gap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s4_ready),
        .i_data  (s3_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    assign m_axis_tdata = {res.next_year, res.next_month, res.next_day, res.month_days_a,
                           res.leap_a, res.day_gap, res.order, res.valid_b, res.valid_a};

endmodule
`default_nettype wire

### rtl/gdu_checker.sv
`default_nettype none
module gdu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    import gdu_pkg::*;

    // an empty output stage lets the whole pipe take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_gap_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3:2] == ORD_EQUAL) |-> m_axis_tdata[25:4] == '0)
        else $error("nonzero gap for equal dates");

    a_gap_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !(m_axis_tdata[0] && m_axis_tdata[1])) |->
        m_axis_tdata[25:4] == '0)
        else $error("nonzero gap for invalid date");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:2] == ORD_EARLIER
            || m_axis_tdata[3:2] == ORD_EQUAL || m_axis_tdata[3:2] == ORD_LATER))
        else $error("bad order code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");

endmodule

bind gregorian_date_unit gdu_checker u_gdu_checker (.*);
`default_nettype wire

### test/tb_gregorian_date_unit.sv
`timescale 1ns / 1ps

module tb_gregorian_date_unit;
    import gdu_pkg::*;

    localparam int unsigned MAX_YEAR     = 9999;
    localparam int unsigned RANDOM_PAIRS = 1500;
    localparam int unsigned LONG_HOLD    = 80;
    localparam int unsigned DRAIN_LIMIT  = 2000;
    localparam int unsigned SETTLE       = 8;
    localparam logic [GAP_W-1:0] GAP_CEIL = '1;

    // same bit order as m_axis_tdata, valid_a in bit 0
    typedef struct packed {
        logic [YEAR_W-1:0] next_year;
        logic [4:0]        next_month;
        logic [4:0]        next_day;
        logic [4:0]        month_days_a;
        logic              leap_a;
        logic [GAP_W-1:0]  day_gap;
        logic [1:0]        order;
        logic              valid_b;
        logic              valid_a;
    } t_date_result;

    typedef struct {
        bit           typed;
        t_date_result want;
    } t_plan;

    typedef struct {
        t_date        a;
        t_date        b;
        bit           typed;
        t_date_result want;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [55:0] m_axis_tdata;

    t_plan        word_plan[$];
    t_date_result awaited_results[$];
    t_row         directed_rows[$];
    int unsigned  errors  = 0;
    bit           no_idle = 1'b0;
    bit           hold_rx = 1'b0;

    t_date_result seen_word;
    t_date_result due_word;
    t_plan        taken_plan;
    t_date        in_a;
    t_date        in_b;

    gregorian_date_unit #(.MAX_YEAR(MAX_YEAR)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int unsigned days_before_month(input int unsigned m);
        case (m)
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    function automatic bit real_date(input t_date dt);
        if (32'(dt.year) > MAX_YEAR || dt.month < 4'd1 || dt.month > MONTHS)
            return 1'b0;
        return dt.day >= 5'd1 && 32'(dt.day) <= month_length(32'(dt.month), 32'(dt.year));
    endfunction

    function automatic longint unsigned day_count(input t_date dt);
        longint unsigned y;
        longint unsigned n;
        y = 64'(dt.year);
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        n += 64'(days_before_month(32'(dt.month)));
        if (dt.month > 4'd2 && leap_year(32'(dt.year)))
            n += 1;
        return n + 64'(dt.day);
    endfunction

    function automatic t_date_result compute_date_result(input t_date a, input t_date b);
        t_date_result    r;
        longint unsigned na;
        longint unsigned nb;
        longint unsigned diff;
        int unsigned     mlen;
        r = '0;
        r.valid_a = real_date(a);
        r.valid_b = real_date(b);
        // year, month, day from the top down: raw fields compare as one vector
        if (a > b)
            r.order = ORD_LATER;
        else if (a == b)
            r.order = ORD_EQUAL;
        else
            r.order = ORD_EARLIER;
        if (r.valid_a && r.valid_b) begin
            na = day_count(a);
            nb = day_count(b);
            diff = (na >= nb) ? na - nb : nb - na;
            r.day_gap = (diff > GAP_CEIL) ? GAP_CEIL : diff[GAP_W-1:0];
        end
        r.leap_a = leap_year(32'(a.year));
        mlen = month_length(32'(a.month), 32'(a.year));
        r.month_days_a = mlen[4:0];
        r.next_day = a.day;
        r.next_month = 5'(a.month);
        r.next_year = a.year;
        if (mlen > 32'(a.day)) begin
            r.next_day = a.day + 5'd1;
        end else begin
            r.next_day = 5'd1;
            if (a.month >= MONTHS) begin
                r.next_month = 5'd1;
                r.next_year = a.year + YEAR_W'(1);
            end else begin
                r.next_month = 5'(a.month) + 5'd1;
            end
        end
        return r;
    endfunction

    function automatic t_date make_date(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
        t_date r;
        r.day = d[4:0];
        r.month = m[3:0];
        r.year = y[YEAR_W-1:0];
        return r;
    endfunction

    function automatic t_date_result known(input bit va, input bit vb, input logic [1:0] ord,
                                           input int unsigned gap, input bit leap,
                                           input int unsigned mdays, input int unsigned nd,
                                           input int unsigned nm, input int unsigned ny);
        t_date_result r;
        r.valid_a = va;
        r.valid_b = vb;
        r.order = ord;
        r.day_gap = gap[GAP_W-1:0];
        r.leap_a = leap;
        r.month_days_a = mdays[4:0];
        r.next_day = nd[4:0];
        r.next_month = nm[4:0];
        r.next_year = ny[YEAR_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input t_date a, input t_date b, input bit typed,
                                    input t_date_result want);
        t_row row;
        row.a = a;
        row.b = b;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic int unsigned idle_draw();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic t_date rand_date();
        t_date       r;
        int unsigned mlen;
        r.year = YEAR_W'($urandom_range(0, MAX_YEAR));
        r.month = 4'($urandom_range(1, 12));
        mlen = month_length(32'(r.month), 32'(r.year));
        r.day = 5'($urandom_range(1, mlen));
        case ($urandom_range(0, 9))
            5: begin
                r.month = 4'd12;
                r.day = 5'd31;
            end
            6: r.day = mlen[4:0];
            7: begin
                r.day = 5'($urandom_range(0, 31));
                r.month = 4'($urandom_range(0, 15));
                r.year = YEAR_W'($urandom_range(0, 16383));
            end
            8: begin
                case ($urandom_range(0, 7))
                    0: r.year = YEAR_W'(0);
                    1: r.year = YEAR_W'(1);
                    2: r.year = YEAR_W'(100);
                    3: r.year = YEAR_W'(400);
                    4: r.year = YEAR_W'(1900);
                    5: r.year = YEAR_W'(2000);
                    6: r.year = YEAR_W'(MAX_YEAR);
                    default: r.year = YEAR_W'(MAX_YEAR + 1);
                endcase
            end
            9: r.day = 5'($urandom_range(0, 31));
            default: ;
        endcase
        return r;
    endfunction

    function automatic string show(input t_date_result r);
        return $sformatf("valid %0d/%0d order %0d gap %0d leap %0d mdays %0d next %0d-%0d-%0d",
                         r.valid_a, r.valid_b, r.order, r.day_gap, r.leap_a, r.month_days_a,
                         r.next_year, r.next_month, r.next_day);
    endfunction

    task automatic note_error(input string what, input t_date_result want,
                              input t_date_result got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected %s, got %s", $realtime, what, show(want), show(got));
    endtask

    task automatic send_pair(input t_date a, input t_date b, input bit typed,
                             input t_date_result want);
        int unsigned idle;
        t_plan       p;
        idle = idle_draw();
        p.typed = typed;
        p.want = want;
        word_plan.push_back(p);
        repeat (idle) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        int unsigned n;
        n = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
    endtask

    // check results, then queue the prediction for the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_word = m_axis_tdata;
                if (awaited_results.size() == 0) begin
                    note_error("unexpected word", '0, seen_word);
                end else begin
                    due_word = awaited_results.pop_front();
                    if (seen_word.valid_a !== due_word.valid_a
                            || seen_word.valid_b !== due_word.valid_b
                            || seen_word.order !== due_word.order
                            || seen_word.day_gap !== due_word.day_gap
                            || seen_word.leap_a !== due_word.leap_a
                            || seen_word.month_days_a !== due_word.month_days_a
                            || seen_word.next_day !== due_word.next_day
                            || seen_word.next_month !== due_word.next_month
                            || seen_word.next_year !== due_word.next_year)
                        note_error("mismatch", due_word, seen_word);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                {in_b, in_a} = s_axis_tdata[45:0];
                taken_plan = word_plan.pop_front();
                if (taken_plan.typed)
                    awaited_results.push_back(taken_plan.want);
                else
                    awaited_results.push_back(compute_date_result(in_a, in_b));
            end
        end
    end

    initial begin
        int unsigned hold;
        wait (i_rst_n);
        forever begin
            hold = idle_draw();
            if (hold_rx) begin
                hold_rx = 1'b0;
                hold = LONG_HOLD;
            end
            repeat (hold) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_date a;
        t_date b;
        int    i;

        add_row(make_date(0, 0, 0), make_date(0, 0, 0), 1'b1,
                known(0, 0, ORD_EQUAL, 0, 1, 0, 1, 1, 0));
        add_row(make_date(31, 12, 9999), make_date(1, 1, 0), 1'b1,
                known(1, 1, ORD_LATER, 3652424, 0, 31, 1, 1, 10000));
        add_row(make_date(1, 1, 0), make_date(31, 12, 9999), 1'b1,
                known(1, 1, ORD_EARLIER, 3652424, 1, 31, 2, 1, 0));
        // next year wraps to zero
        add_row(make_date(31, 15, 16383), make_date(31, 15, 16383), 1'b1,
                known(0, 0, ORD_EQUAL, 0, 0, 0, 1, 1, 0));
        add_row(make_date(0, 5, 2023), make_date(1, 1, 2023), 1'b1,
                known(0, 1, ORD_LATER, 0, 0, 31, 1, 5, 2023));
        add_row(make_date(1, 1, 10000), make_date(1, 1, 2000), 1'b1,
                known(0, 1, ORD_LATER, 0, 1, 31, 2, 1, 10000));
        add_row(make_date(5, 13, 2020), make_date(5, 13, 2020), 1'b1,
                known(0, 0, ORD_EQUAL, 0, 1, 0, 1, 1, 2021));
        add_row(make_date(29, 2, 2000), make_date(29, 2, 2000), 1'b1,
                known(1, 1, ORD_EQUAL, 0, 1, 29, 1, 3, 2000));
        add_row(make_date(29, 2, 1900), make_date(28, 2, 1900), 1'b0, '0);
        add_row(make_date(28, 2, 1900), make_date(1, 3, 1900), 1'b0, '0);
        add_row(make_date(29, 2, 2024), make_date(1, 3, 2023), 1'b0, '0);
        add_row(make_date(31, 12, 2023), make_date(1, 1, 2024), 1'b0, '0);
        add_row(make_date(31, 4, 2021), make_date(30, 4, 2021), 1'b0, '0);
        add_row(make_date(10, 0, 2000), make_date(10, 14, 2000), 1'b0, '0);
        add_row(make_date(31, 1, 2022), make_date(31, 1, 2021), 1'b0, '0);
        add_row(make_date(30, 11, 1999), make_date(1, 12, 1999), 1'b0, '0);
        add_row(make_date(15, 6, 100), make_date(15, 6, 400), 1'b0, '0);
        add_row(make_date(31, 2, 2004), make_date(0, 0, 9999), 1'b0, '0);
        add_row(make_date(1, 1, 9999), make_date(31, 12, 9999), 1'b0, '0);
        add_row(make_date(31, 12, 16383), make_date(1, 1, 10000), 1'b0, '0);
        add_row(make_date(28, 2, 2100), make_date(29, 2, 2096), 1'b0, '0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_pair(directed_rows[k].a, directed_rows[k].b, directed_rows[k].typed,
                      directed_rows[k].want);
        wait_drained();

        for (i = 0; i < RANDOM_PAIRS; i++) begin
            no_idle = ((i / 250) % 3 == 1);
            // stall the output long enough to back up the pipeline
            if (i == 400 || i == 1100)
                hold_rx = 1'b1;
            if (i == 700)
                wait_drained();
            a = rand_date();
            case ($urandom_range(0, 3))
                0: b = a;
                1: begin
                    b = a;
                    b.day = 5'($urandom_range(1, 28));
                end
                2: begin
                    b = rand_date();
                    b.year = a.year;
                end
                default: b = rand_date();
            endcase
            send_pair(a, b, 1'b0, '0);
        end

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
